>>> design/multilevel_feedback_queue_scheduler_assert.svh
// Assertion macros for the feedback queue scheduler.
// Used by the top level; expects signals named clk and rst_n in scope.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define MFQ_CHECK(lbl, ante, cons) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (ante) |-> (cons)) else $error("mfq check failed");
`define MFQ_CHECK_NEXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
  disable iff (!rst_n) (ante) |=> (cons)) else $error("mfq sequence check failed");
`else
`define MFQ_CHECK(lbl, ante, cons)
`define MFQ_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/mfq_pkg.sv
// Shared types and constants for the feedback queue scheduler.
// No dependencies.
package mfq_pkg;

  localparam int TASK_SLOTS_DEF  = 64;
  localparam int LEVELS_DEF      = 4;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int TIME_W  = 28;
  localparam int EXEC_W  = 25;
  localparam int ARR_W   = 20;
  localparam int LEN_W   = 24;
  localparam int DCNT_W  = 16;
  localparam int BQ_W    = 8;
  localparam int SLOUT_W = 10;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [EXEC_W-1:0] EXEC_MAX = {EXEC_W{1'b1}};
  localparam logic [DCNT_W-1:0] DCNT_MAX = {DCNT_W{1'b1}};
  localparam logic [BQ_W-1:0]   BQ_RESET = 8'd1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef enum logic [2:0] {
    STAT_LOADED     = 3'd0,
    STAT_DISPATCHED = 3'd1,
    STAT_IDLE_TICK  = 3'd2,
    STAT_ALL_DONE   = 3'd3,
    STAT_REJECTED   = 3'd4
  } status_t;

  typedef struct packed {
    logic              op;
    logic [ARR_W-1:0]  task_arrival;
    logic [LEN_W-1:0]  task_length;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [5:0]          task_id;
    logic [1:0]          level;
    logic [SLOUT_W-1:0]  slice_ticks;
    logic                finished;
    logic [TIME_W-1:0]   done_time;
    logic [DCNT_W-1:0]   dispatch_count;
    logic [TIME_W-1:0]   current_time;
  } out_item_t;

  typedef struct packed {
    logic [ARR_W-1:0]  arrival;
    logic [LEN_W-1:0]  length;
    logic [EXEC_W-1:0] executed;
    logic [DCNT_W-1:0] dcnt;
  } task_word_t;

endpackage

>>> design/multilevel_feedback_queue_scheduler.sv
// Top level of the feedback queue scheduler: control FSM, level rings, time.
// Depends on mfq_pkg, mfq_task_mem and the assertion header.
//
//   port group  | direction | handshake          | word
//   in_         | input     | in_valid/in_ready  | mfq_pkg::in_item_t
//   out_        | output    | out_valid/out_ready| mfq_pkg::out_item_t
//   cfg_        | input     | cfg_we             | base quantum, 8 bits
//
// From accept to the next accept: a load passes S_LOAD; a step ends in S_STEP
// when all tasks are done, else goes through S_ADM_RD and S_ADM_WAIT per
// admitted task (S_ADM_WAIT also for the failing arrival check), then S_SEL,
// and for a dispatch S_Q_WAIT and S_T_WAIT. One item is in work at a time.
// The result sits in an output register; the next word is taken while it waits.
// Reset clears counters, ring pointers, time and the FSM; memories are not
// cleared and are only read at entries already written.
`include "multilevel_feedback_queue_scheduler_assert.svh"
module multilevel_feedback_queue_scheduler #(
  parameter int TASK_SLOTS  = mfq_pkg::TASK_SLOTS_DEF,
  parameter int LEVELS      = mfq_pkg::LEVELS_DEF,
  parameter int QUEUE_DEPTH = mfq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mfq_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mfq_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [mfq_pkg::BQ_W-1:0]  cfg_wdata
);

  localparam int TW   = $clog2(TASK_SLOTS);
  localparam int CW   = $clog2(TASK_SLOTS + 1);
  localparam int LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LPW  = $clog2(LEVELS + 1);
  localparam int QIW  = $clog2(QUEUE_DEPTH);
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW   = mfq_pkg::BQ_W + LPW;
  localparam int S16W = SW + 4;
  localparam int TOTW = QCW + LPW;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_LOAD     = 8'b0000_0010,
    S_STEP     = 8'b0000_0100,
    S_ADM_RD   = 8'b0000_1000,
    S_ADM_WAIT = 8'b0001_0000,
    S_SEL      = 8'b0010_0000,
    S_Q_WAIT   = 8'b0100_0000,
    S_T_WAIT   = 8'b1000_0000
  } state_t;

  state_t                          state_r, state_nxt;
  mfq_pkg::in_item_t               item_r, item_nxt;
  mfq_pkg::out_item_t              out_r, out_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [mfq_pkg::BQ_W-1:0]        bq_r, bq_nxt;
  logic [mfq_pkg::TIME_W-1:0]      time_r, time_nxt;
  logic [CW-1:0]                   loaded_r, loaded_nxt;
  logic [CW-1:0]                   admitted_r, admitted_nxt;
  logic [CW-1:0]                   completed_r, completed_nxt;
  logic [QIW-1:0]                  head_r [LEVELS];
  logic [QIW-1:0]                  head_nxt [LEVELS];
  logic [QCW-1:0]                  cnt_r [LEVELS];
  logic [QCW-1:0]                  cnt_nxt [LEVELS];
  logic [LW-1:0]                   lvl_r, lvl_nxt;

  // task memory port
  logic                            tm_we, tm_re;
  logic [TW-1:0]                   tm_waddr, tm_raddr;
  mfq_pkg::task_word_t             tm_wdata, tm_rdata;

  // ring memory
  logic [TW-1:0]                   qmem [LEVELS][QUEUE_DEPTH];
  logic                            q_we, q_re;
  logic [LW-1:0]                   q_wlvl, q_rlvl;
  logic [QIW-1:0]                  q_widx, q_ridx;
  logic [TW-1:0]                   q_wdata, q_rdata;

  // dispatch datapath
  logic                            found;
  logic [LW-1:0]                   sel_lvl;
  logic [LW-1:0]                   next_lvl;
  logic [SW-1:0]                   slice;
  logic [S16W-1:0]                 slice16;
  logic [mfq_pkg::EXEC_W:0]        exec_sum;
  logic [mfq_pkg::EXEC_W-1:0]      exec;
  logic [mfq_pkg::EXEC_W-1:0]      fragment;
  logic [mfq_pkg::EXEC_W-1:0]      used;
  logic                            fin;
  logic [mfq_pkg::DCNT_W-1:0]      dcnt_inc;
  logic                            out_free;
  logic [TOTW-1:0]                 qtotal;

  function automatic logic [mfq_pkg::TIME_W-1:0] sat_add(
    input logic [mfq_pkg::TIME_W-1:0] t,
    input logic [mfq_pkg::TIME_W-1:0] d
  );
    logic [mfq_pkg::TIME_W:0] s;
    s = {1'b0, t} + {1'b0, d};
    return s[mfq_pkg::TIME_W] ? mfq_pkg::TIME_MAX : s[mfq_pkg::TIME_W-1:0];
  endfunction

  function automatic logic [QIW-1:0] tail_idx(
    input logic [QIW-1:0] h,
    input logic [QCW-1:0] c
  );
    logic [QCW:0] s;
    s = (QCW + 1)'(h) + (QCW + 1)'(c);
    if (s >= (QCW + 1)'(QUEUE_DEPTH)) begin
      s = s - (QCW + 1)'(QUEUE_DEPTH);
    end
    return s[QIW-1:0];
  endfunction

  mfq_task_mem #(.DEPTH(TASK_SLOTS)) u_task_mem (
    .clk   (clk),
    .we    (tm_we),
    .waddr (tm_waddr),
    .wdata (tm_wdata),
    .re    (tm_re),
    .raddr (tm_raddr),
    .rdata (tm_rdata)
  );

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_wlvl][q_widx] <= q_wdata;
    end
    if (q_re) begin
      q_rdata <= qmem[q_rlvl][q_ridx];
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  // lowest non-empty level
  always_comb begin
    found   = 1'b0;
    sel_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        found   = 1'b1;
        sel_lvl = LW'(i);
      end
    end
  end

  always_comb begin
    qtotal = '0;
    for (int i = 0; i < LEVELS; i++) begin
      qtotal = qtotal + TOTW'(cnt_r[i]);
    end
  end

  // slice and completion math on the fetched task record
  always_comb begin
    slice    = SW'(bq_r) * (SW'(lvl_r) + SW'(1));
    slice16  = {slice, 4'b0000};
    exec_sum = {1'b0, tm_rdata.executed} + (mfq_pkg::EXEC_W + 1)'(slice16);
    exec     = exec_sum[mfq_pkg::EXEC_W] ? mfq_pkg::EXEC_MAX
                                         : exec_sum[mfq_pkg::EXEC_W-1:0];
    fin      = exec >= mfq_pkg::EXEC_W'(tm_rdata.length);
    fragment = exec - mfq_pkg::EXEC_W'(tm_rdata.length);
    used     = (fragment > mfq_pkg::EXEC_W'(slice16)) ? '0
                                                      : mfq_pkg::EXEC_W'(slice16) - fragment;
    dcnt_inc = (tm_rdata.dcnt == mfq_pkg::DCNT_MAX) ? tm_rdata.dcnt
                                                    : tm_rdata.dcnt + 1'b1;
    next_lvl = (32'(lvl_r) + 1 < LEVELS) ? lvl_r + 1'b1 : LW'(LEVELS - 1);
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    bq_nxt        = cfg_we ? cfg_wdata : bq_r;
    time_nxt      = time_r;
    loaded_nxt    = loaded_r;
    admitted_nxt  = admitted_r;
    completed_nxt = completed_r;
    lvl_nxt       = lvl_r;
    for (int i = 0; i < LEVELS; i++) begin
      head_nxt[i] = head_r[i];
      cnt_nxt[i]  = cnt_r[i];
    end
    tm_we    = 1'b0;
    tm_waddr = loaded_r[TW-1:0];
    tm_wdata = '0;
    tm_re    = 1'b0;
    tm_raddr = admitted_r[TW-1:0];
    q_we     = 1'b0;
    q_wlvl   = '0;
    q_widx   = tail_idx(head_r[0], cnt_r[0]);
    q_wdata  = admitted_r[TW-1:0];
    q_re     = 1'b0;
    q_rlvl   = sel_lvl;
    q_ridx   = head_r[sel_lvl];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = (in_data.op == mfq_pkg::OP_STEP) ? S_STEP : S_LOAD;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          out_nxt              = '0;
          out_nxt.current_time = time_r;
          if (loaded_r >= CW'(TASK_SLOTS)) begin
            out_nxt.status = mfq_pkg::STAT_REJECTED;
          end else begin
            tm_we             = 1'b1;
            tm_wdata.arrival  = item_r.task_arrival;
            tm_wdata.length   = item_r.task_length;
            out_nxt.status    = mfq_pkg::STAT_LOADED;
            out_nxt.task_id   = 6'(loaded_r[TW-1:0]);
            loaded_nxt        = loaded_r + 1'b1;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_STEP: begin
        if (completed_r >= loaded_r) begin
          if (out_free) begin
            out_nxt              = '0;
            out_nxt.status       = mfq_pkg::STAT_ALL_DONE;
            out_nxt.current_time = time_r;
            out_valid_nxt        = 1'b1;
            state_nxt            = S_IDLE;
          end
        end else begin
          state_nxt = S_ADM_RD;
        end
      end
      S_ADM_RD: begin
        if (admitted_r < loaded_r && cnt_r[0] < QCW'(QUEUE_DEPTH)) begin
          tm_re     = 1'b1;
          state_nxt = S_ADM_WAIT;
        end else begin
          state_nxt = S_SEL;
        end
      end
      S_ADM_WAIT: begin
        // arrival is in whole ticks, time in sixteenths
        if ({tm_rdata.arrival, 4'b0000} <= time_r[mfq_pkg::ARR_W+3:0] &&
            time_r[mfq_pkg::TIME_W-1:mfq_pkg::ARR_W+4] == '0 ||
            time_r[mfq_pkg::TIME_W-1:mfq_pkg::ARR_W+4] != '0) begin
          q_we         = 1'b1;
          cnt_nxt[0]   = cnt_r[0] + 1'b1;
          admitted_nxt = admitted_r + 1'b1;
          state_nxt    = S_ADM_RD;
        end else begin
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        if (!found) begin
          if (out_free) begin
            out_nxt              = '0;
            out_nxt.status       = mfq_pkg::STAT_IDLE_TICK;
            time_nxt             = sat_add(time_r, mfq_pkg::TIME_W'(16));
            out_nxt.current_time = time_nxt;
            out_valid_nxt        = 1'b1;
            state_nxt            = S_IDLE;
          end
        end else begin
          q_re              = 1'b1;
          lvl_nxt           = sel_lvl;
          head_nxt[sel_lvl] = (32'(head_r[sel_lvl]) + 1 >= QUEUE_DEPTH) ? '0
                                                                       : head_r[sel_lvl] + 1'b1;
          cnt_nxt[sel_lvl]  = cnt_r[sel_lvl] - 1'b1;
          state_nxt         = S_Q_WAIT;
        end
      end
      S_Q_WAIT: begin
        tm_re     = 1'b1;
        tm_raddr  = q_rdata;
        state_nxt = S_T_WAIT;
      end
      S_T_WAIT: begin
        if (out_free) begin
          tm_we                  = 1'b1;
          tm_waddr               = q_rdata;
          tm_wdata               = tm_rdata;
          tm_wdata.dcnt          = dcnt_inc;
          out_nxt                = '0;
          out_nxt.status         = mfq_pkg::STAT_DISPATCHED;
          out_nxt.task_id        = 6'(q_rdata);
          out_nxt.level          = 2'(lvl_r);
          out_nxt.slice_ticks    = (slice > SW'(1023)) ? 10'd1023 : 10'(slice);
          out_nxt.dispatch_count = dcnt_inc;
          if (fin) begin
            tm_wdata.executed   = mfq_pkg::EXEC_W'(tm_rdata.length);
            time_nxt            = sat_add(time_r, mfq_pkg::TIME_W'(used));
            completed_nxt       = completed_r + 1'b1;
            out_nxt.finished    = 1'b1;
            out_nxt.done_time   = time_nxt;
          end else begin
            tm_wdata.executed = exec;
            time_nxt          = sat_add(time_r, mfq_pkg::TIME_W'(slice16));
            // demote, or stay put when the lower ring is full
            q_we    = 1'b1;
            q_wdata = q_rdata;
            if (cnt_r[next_lvl] < QCW'(QUEUE_DEPTH)) begin
              q_wlvl            = next_lvl;
              q_widx            = tail_idx(head_r[next_lvl], cnt_r[next_lvl]);
              cnt_nxt[next_lvl] = cnt_r[next_lvl] + 1'b1;
            end else begin
              q_wlvl         = lvl_r;
              q_widx         = tail_idx(head_r[lvl_r], cnt_r[lvl_r]);
              cnt_nxt[lvl_r] = cnt_r[lvl_r] + 1'b1;
            end
          end
          out_nxt.current_time = time_nxt;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bq_r        <= mfq_pkg::BQ_RESET;
      time_r      <= '0;
      loaded_r    <= '0;
      admitted_r  <= '0;
      completed_r <= '0;
      lvl_r       <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bq_r        <= bq_nxt;
      time_r      <= time_nxt;
      loaded_r    <= loaded_nxt;
      admitted_r  <= admitted_nxt;
      completed_r <= completed_nxt;
      lvl_r       <= lvl_nxt;
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= head_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
    end
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  `MFQ_CHECK(a_count_order, 1'b1, completed_r <= admitted_r && admitted_r <= loaded_r)
  `MFQ_CHECK(a_rings_hold_live, state_r == S_IDLE, qtotal == TOTW'(admitted_r - completed_r))
  `MFQ_CHECK_NEXT(a_adm_read, state_r == S_ADM_RD && tm_re, state_r == S_ADM_WAIT)
  `MFQ_CHECK_NEXT(a_word_taken, in_valid && in_ready, state_r == S_LOAD || state_r == S_STEP)

endmodule

>>> design/mfq_task_mem.sv
// Per-task record memory: one write port, one registered read port.
// Depends on mfq_pkg for the record layout.
module mfq_task_mem #(
  parameter int DEPTH = mfq_pkg::TASK_SLOTS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  mfq_pkg::task_word_t wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output mfq_pkg::task_word_t rdata
);

  mfq_pkg::task_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
